### hw/rtl/fbpa_pkg.sv
`default_nettype none

package fbpa_pkg;

    localparam int ADDR_W      = 32;
    localparam int SIZE_W      = 17;
    localparam int COUNT_W     = 7;
    localparam int INDEX_W     = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // The used map is stored in rows of ROW_BITS blocks.
    localparam int BIT_SEL_W   = 3;
    localparam int ROW_BITS    = 2 ** BIT_SEL_W;

    // One quotient bit per step of the restoring divider.
    localparam int DIV_STEPS   = ADDR_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam int DEFAULT_MAX_BLOCKS = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT  = 2'd2;

    localparam logic [ADDR_W-1:0]  RST_BASE_ADDRESS = 32'd0;
    localparam logic [SIZE_W-1:0]  RST_BLOCK_SIZE   = 17'd4096;
    localparam logic [COUNT_W-1:0] RST_BLOCK_COUNT  = 7'd64;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_INVALID      = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } t_status;

    typedef struct packed {
        t_opcode           opcode;
        logic [ADDR_W-1:0] address;
    } t_alloc_req;

    typedef struct packed {
        t_status            status;
        logic [ADDR_W-1:0]  block_address;
        logic [INDEX_W-1:0] slot_index;
        logic [COUNT_W-1:0] blocks_in_use;
    } t_alloc_resp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    scan_clr;
        logic    scan_next;
        logic    rd_en;
        logic    rd_sel_quot;
        logic    alloc_commit;
        logic    div_init;
        logic    div_step;
        logic    free_eval;
        logic    load_out;
        t_status status;
        logic    addr_en;
        logic    idx_en;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_opcode opcode;
        logic    room;
        logic    addr_bad;
        logic    found;
        logic    more_rows;
        logic    div_last;
        logic    idx_bad;
        logic    bit_set;
    } t_dp_stat;

endpackage

`default_nettype wire

### hw/rtl/fbpa_datapath.sv
`default_nettype none

module fbpa_datapath #(
    parameter int MAX_BLOCKS = fbpa_pkg::DEFAULT_MAX_BLOCKS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  fbpa_pkg::t_alloc_req                i_req,
    input  fbpa_pkg::t_dp_cmd                   i_cmd,
    output fbpa_pkg::t_dp_stat                  o_stat,
    output fbpa_pkg::t_alloc_resp               o_resp
);
    import fbpa_pkg::*;

    localparam int ROWS   = (MAX_BLOCKS + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W  = ROW_AW + BIT_SEL_W;
    localparam int PROD_W = IDX_W + SIZE_W;
    localparam logic [COUNT_W-1:0] MAX_COUNT =
        (MAX_BLOCKS >= (2 ** COUNT_W) - 1) ? {COUNT_W{1'b1}} : COUNT_W'(MAX_BLOCKS);

    // Configuration.
    logic [ADDR_W-1:0]   r_base;
    logic [SIZE_W-1:0]   r_size;
    logic [COUNT_W-1:0]  r_count;

    // Request and allocator state.
    t_opcode             r_opcode;
    logic [ADDR_W-1:0]   r_address;
    logic [COUNT_W-1:0]  r_used;
    logic [ROWS-1:0]     r_row_valid;
    logic [ROW_BITS-1:0] r_map [ROWS];
    logic [ROW_BITS-1:0] r_rd_data;
    logic [ROW_AW-1:0]   r_scan_row;
    logic [IDX_W-1:0]    r_idx;
    logic [PROD_W-1:0]   r_prod;
    t_alloc_resp         r_resp;

    // Divider.
    logic [ADDR_W-1:0]   r_div_q;
    logic [SIZE_W:0]     r_div_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    logic [SIZE_W-1:0]   eff_size;
    logic [COUNT_W-1:0]  eff_count;
    logic [ADDR_W-1:0]   offset;
    logic [SIZE_W:0]     rem_shift;
    logic                rem_ge;
    logic [SIZE_W:0]     rem_next;
    logic [ROW_AW-1:0]   q_row;
    logic [BIT_SEL_W-1:0] q_bit;
    logic [ROW_AW-1:0]   rd_addr;
    logic [ROW_BITS-1:0] cand;
    logic [BIT_SEL_W-1:0] pick;
    logic [ROW_BITS-1:0] pick_mask;
    logic [ROW_BITS-1:0] q_mask;
    logic                bit_set;
    logic                wr_en;
    logic [ROW_AW-1:0]   wr_addr;
    logic [ROW_BITS-1:0] wr_data;

    assign eff_size  = (r_size == '0) ? SIZE_W'(1) : r_size;
    assign eff_count = (32'(r_count) > MAX_BLOCKS) ? MAX_COUNT : r_count;
    assign offset    = r_address - r_base;

    assign rem_shift = {r_div_rem[SIZE_W-1:0], r_div_q[ADDR_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, eff_size});
    assign rem_next  = rem_ge ? (rem_shift - {1'b0, eff_size}) : rem_shift;

    assign q_row   = r_div_q[IDX_W-1:BIT_SEL_W];
    assign q_bit   = r_div_q[BIT_SEL_W-1:0];
    assign rd_addr = i_cmd.rd_sel_quot ? q_row : r_scan_row;

    // Free blocks in the row just read, limited to indexes below the count.
    always_comb begin
        cand = '0;
        pick = '0;
        for (int b = 0; b < ROW_BITS; b++) begin
            cand[b] = !r_rd_data[b] &&
                      (32'({r_scan_row, BIT_SEL_W'(b)}) < 32'(eff_count));
        end
        for (int b = ROW_BITS - 1; b >= 0; b--) begin
            if (cand[b]) begin
                pick = BIT_SEL_W'(b);
            end
        end
    end

    assign pick_mask = ROW_BITS'(1) << pick;
    assign q_mask    = ROW_BITS'(1) << q_bit;
    assign bit_set   = r_rd_data[q_bit];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_scan_row;
        wr_data = r_rd_data | pick_mask;
        if (i_cmd.alloc_commit) begin
            wr_en = 1'b1;
        end else if (i_cmd.free_eval && bit_set) begin
            wr_en   = 1'b1;
            wr_addr = q_row;
            wr_data = r_rd_data & ~q_mask;
        end
    end

    assign o_stat.opcode    = r_opcode;
    assign o_stat.room      = (r_used < eff_count);
    assign o_stat.addr_bad  = (r_address == '0) || (r_address < r_base);
    assign o_stat.found     = |cand;
    assign o_stat.more_rows =
        (32'({r_scan_row, BIT_SEL_W'(0)}) + 32'(ROW_BITS)) < 32'(eff_count);
    assign o_stat.div_last  = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    assign o_stat.idx_bad   = (r_div_q >= 32'(eff_count));
    assign o_stat.bit_set   = bit_set;

    assign o_resp = r_resp;

    // Configuration, used counter and row valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= RST_BASE_ADDRESS;
            r_size      <= RST_BLOCK_SIZE;
            r_count     <= RST_BLOCK_COUNT;
            r_used      <= '0;
            r_row_valid <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE_ADDRESS: r_base  <= i_cfg_data;
                    CFG_BLOCK_SIZE:   r_size  <= i_cfg_data[SIZE_W-1:0];
                    CFG_BLOCK_COUNT:  r_count <= i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (wr_en) begin
                r_row_valid[wr_addr] <= 1'b1;
            end
            if (i_cmd.alloc_commit) begin
                r_used <= r_used + COUNT_W'(1);
            end else if (i_cmd.free_eval && bit_set && (r_used != '0)) begin
                r_used <= r_used - COUNT_W'(1);
            end
        end
    end

    // Used map rows. A row never written reads as all free.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_row_valid[rd_addr] ? r_map[rd_addr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_opcode  <= i_req.opcode;
            r_address <= i_req.address;
        end

        if (i_cmd.scan_clr) begin
            r_scan_row <= '0;
        end else if (i_cmd.scan_next) begin
            r_scan_row <= r_scan_row + ROW_AW'(1);
        end

        if (i_cmd.div_init) begin
            r_div_q   <= offset;
            r_div_rem <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_q   <= {r_div_q[ADDR_W-2:0], rem_ge};
            r_div_rem <= rem_next;
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end

        if (i_cmd.alloc_commit) begin
            r_idx <= {r_scan_row, pick};
        end else if (i_cmd.free_eval) begin
            r_idx <= r_div_q[IDX_W-1:0];
        end

        r_prod <= {{SIZE_W{1'b0}}, r_idx} * {{IDX_W{1'b0}}, eff_size};

        if (i_cmd.load_out) begin
            r_resp.status        <= i_cmd.status;
            r_resp.block_address <= i_cmd.addr_en ? (r_base + 32'(r_prod)) : '0;
            r_resp.slot_index    <= i_cmd.idx_en ? INDEX_W'(r_idx) : '0;
            r_resp.blocks_in_use <= r_used;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/fbpa_ctrl.sv
`default_nettype none

module fbpa_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  fbpa_pkg::t_dp_stat  i_stat,
    output fbpa_pkg::t_dp_cmd   o_cmd
);
    import fbpa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_A_READ,
        S_A_EVAL,
        S_A_MUL,
        S_F_DIV,
        S_F_CHECK,
        S_F_EVAL,
        S_FINISH
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    t_status r_status, n_status;
    logic    r_addr_en, n_addr_en;
    logic    r_idx_en, n_idx_en;
    logic    out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_addr_en   = r_addr_en;
        n_idx_en    = r_idx_en;
        n_out_valid = r_out_valid && i_out_stall;

        o_cmd         = '0;
        o_cmd.status  = r_status;
        o_cmd.addr_en = r_addr_en;
        o_cmd.idx_en  = r_idx_en;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_addr_en = 1'b0;
                n_idx_en  = 1'b0;
                if (i_stat.opcode == OP_ALLOC) begin
                    if (i_stat.room) begin
                        o_cmd.scan_clr = 1'b1;
                        n_state        = S_A_READ;
                    end else begin
                        n_status = ST_FULL;
                        n_state  = S_FINISH;
                    end
                end else begin
                    if (i_stat.addr_bad) begin
                        n_status = ST_INVALID;
                        n_state  = S_FINISH;
                    end else begin
                        o_cmd.div_init = 1'b1;
                        n_state        = S_F_DIV;
                    end
                end
            end
            S_A_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_A_EVAL;
            end
            S_A_EVAL: begin
                if (i_stat.found) begin
                    o_cmd.alloc_commit = 1'b1;
                    n_status           = ST_OK;
                    n_addr_en          = 1'b1;
                    n_idx_en           = 1'b1;
                    n_state            = S_A_MUL;
                end else if (i_stat.more_rows) begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = S_A_READ;
                end else begin
                    n_status = ST_FULL;
                    n_state  = S_FINISH;
                end
            end
            S_A_MUL: begin
                // The block offset product settles in this cycle.
                n_state = S_FINISH;
            end
            S_F_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_F_CHECK;
                end
            end
            S_F_CHECK: begin
                // A quotient at or past the count means the offset lies past the pool end.
                if (i_stat.idx_bad) begin
                    n_status = ST_INVALID;
                    n_state  = S_FINISH;
                end else begin
                    o_cmd.rd_en       = 1'b1;
                    o_cmd.rd_sel_quot = 1'b1;
                    n_state           = S_F_EVAL;
                end
            end
            S_F_EVAL: begin
                o_cmd.free_eval = 1'b1;
                n_status        = i_stat.bit_set ? ST_OK : ST_ALREADY_FREE;
                n_idx_en        = 1'b1;
                n_state         = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_status    <= ST_OK;
            r_addr_en   <= 1'b0;
            r_idx_en    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_status    <= n_status;
            r_addr_en   <= n_addr_en;
            r_idx_en    <= n_idx_en;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/fixed_block_pool_allocator.sv
`default_nettype none

// Channel    Direction  Handshake                    Word
// request    in         i_in_valid / o_in_stall      i_in_data  (opcode, address)
// response   out        o_out_valid / i_out_stall    o_out_data (status, address, index, count)
// config     in         i_cfg_we                     i_cfg_index, i_cfg_data
//
// One request at a time. An allocate reads and checks the used map one row of eight
// blocks at a time until it finds a free block or reaches the count.
// A free runs the 32-step restoring divider to turn the address offset into a slot index.
// Synchronous active-low reset clears the map (row valid bits) and the used counter.
// A finished word waits in the output register while the next request is taken.

module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = fbpa_pkg::DEFAULT_MAX_BLOCKS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  fbpa_pkg::t_alloc_req             i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output fbpa_pkg::t_alloc_resp            o_out_data
);
    import fbpa_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    fbpa_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_resp      (o_out_data)
    );

    fbpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

endmodule

`default_nettype wire
